/* hw/rtl/pcmdec_pkg.sv */
// Shared types, register indexes and the mu-law expansion for the PCM sample decoder.
// Used by every decoder module but pcmdec_checker; depends on nothing else.
`default_nettype none

package pcmdec_pkg;

   localparam int BLOCK_SAMPLES_DEFAULT = 128;
   localparam int MAX_CHANNELS_DEFAULT  = 8;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_FORMAT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'b1;

   localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd1;

   typedef enum logic [2:0] {
      FMT_U8    = 3'd0,
      FMT_S8    = 3'd1,
      FMT_ULAW  = 3'd2,
      FMT_S16LE = 3'd3,
      FMT_S16BE = 3'd4
   } fmt_type;

   typedef struct packed {
      logic        produce;
      logic [15:0] sample;
   } decode_type;

   typedef struct packed {
      logic [2:0] channel_index;
      logic [6:0] frame_index;
      logic       block_end;
   } tag_type;

   // Standard G.711 mu-law expansion; the magnitude peaks at 32124.
   function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
      logic [7:0]  u;
      logic [15:0] mag;
      u   = ~code;
      mag = ((16'({u[3:0], 3'b000}) + 16'd132) << u[6:4]) - 16'd132;
      return u[7] ? (~mag + 16'd1) : mag;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcmdec_byte_decode.sv */
// Byte-to-sample conversion for the five sample formats, with the held first byte
// of a 16-bit sample. Depends on pcmdec_pkg.
`default_nettype none

module pcmdec_byte_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [7:0]           data_byte,
   input  wire pcmdec_pkg::fmt_type  sample_format,
   output pcmdec_pkg::decode_type    decode
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       phase_ff, phase_in;

   always_comb begin
      held_byte_in   = held_byte_ff;
      phase_in       = 1'b0;
      decode.produce = 1'b1;
      decode.sample  = {~data_byte[7], data_byte[6:0], 8'h00};
      unique case (sample_format)
         pcmdec_pkg::FMT_S8: begin
            decode.sample = {data_byte, 8'h00};
         end
         pcmdec_pkg::FMT_ULAW: begin
            decode.sample = pcmdec_pkg::ulaw_expand(data_byte);
         end
         pcmdec_pkg::FMT_S16LE, pcmdec_pkg::FMT_S16BE: begin
            if (!phase_ff) begin
               held_byte_in   = data_byte;
               phase_in       = 1'b1;
               decode.produce = 1'b0;
            end else if (sample_format == pcmdec_pkg::FMT_S16LE) begin
               decode.sample = {data_byte, held_byte_ff};
            end else begin
               decode.sample = {held_byte_ff, data_byte};
            end
         end
         default: begin
            decode.sample = {~data_byte[7], data_byte[6:0], 8'h00};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         held_byte_ff <= 8'h00;
      end else if (advance) begin
         phase_ff     <= phase_in;
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pcmdec_sample_tagger.sv */
// Channel and frame counters that tag each sample and flag the end of a block.
// Depends on pcmdec_pkg.
`default_nettype none

module pcmdec_sample_tagger #(
   parameter int BLOCK_SAMPLES = pcmdec_pkg::BLOCK_SAMPLES_DEFAULT,
   parameter int MAX_CHANNELS  = pcmdec_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [3:0]        channel_count,
   output pcmdec_pkg::tag_type    tag
);

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FR_W  = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam int CMP_W = (CH_W + 1 > 5) ? CH_W + 1 : 5;
   localparam int CHX_W = (CH_W > 3) ? CH_W : 3;
   localparam int FRX_W = (FR_W > 7) ? FR_W : 7;

   logic [CH_W-1:0]  chan_ff, chan_in;
   logic [FR_W-1:0]  frame_ff, frame_in;
   logic [CMP_W-1:0] chans_eff;
   logic             last_chan, last_frame;
   logic [CHX_W-1:0] chan_ext;
   logic [FRX_W-1:0] frame_ext;

   always_comb begin
      if (channel_count == 4'd0) begin
         chans_eff = CMP_W'(1);
      end else if (CMP_W'(channel_count) > CMP_W'(MAX_CHANNELS)) begin
         chans_eff = CMP_W'(MAX_CHANNELS);
      end else begin
         chans_eff = CMP_W'(channel_count);
      end
      last_chan  = (CMP_W'(chan_ff) + CMP_W'(1)) >= chans_eff;
      last_frame = (frame_ff == FR_W'(BLOCK_SAMPLES - 1));

      chan_in  = chan_ff + CH_W'(1);
      frame_in = frame_ff;
      if (last_chan) begin
         chan_in  = '0;
         frame_in = last_frame ? '0 : frame_ff + FR_W'(1);
      end

      chan_ext          = CHX_W'(chan_ff);
      frame_ext         = FRX_W'(frame_ff);
      tag.channel_index = chan_ext[2:0];
      tag.frame_index   = frame_ext[6:0];
      tag.block_end     = last_chan && last_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         frame_ff <= '0;
      end else if (advance) begin
         chan_ff  <= chan_in;
         frame_ff <= frame_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pcm_ulaw_sample_decoder_unit.sv */
// Top level of the PCM and mu-law sample decoder: input register, configuration
// registers and result register. Depends on pcmdec_pkg, pcmdec_byte_decode and
// pcmdec_sample_tagger.
//
// Usage: raw sample bytes arrive on the req_ channel, one per transfer, and decoded
// signed 16-bit samples leave on the rsp_ channel with their channel number, frame
// index within the block and a flag on the last sample of a block. The csr_ port
// selects the format (register 0) and the channel count (register 1); write it only
// while no byte is in flight.
// The input stage registers each byte on transfer; the result register takes the
// sample a byte completes when the input stage moves on. An 8-bit format gives one
// sample per byte; a 16-bit one per two bytes, the first byte producing nothing.
// Throughput: one byte per cycle while no result is held, set by the single input
// stage and single result register, both of which refill in the cycle they empty.
// Reset clears the format to unsigned 8-bit, the channel count to one, the counters,
// the byte phase and both stages. While rsp_stall is high the result holds; a byte
// that yields no sample still moves on, and once the input stage is blocked behind a
// held result, req_stall rises.
`default_nettype none

module pcm_ulaw_sample_decoder_unit #(
   parameter int BLOCK_SAMPLES = pcmdec_pkg::BLOCK_SAMPLES_DEFAULT,
   parameter int MAX_CHANNELS  = pcmdec_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [pcmdec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pcmdec_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [15:0]                      rsp_sample,
   output logic [2:0]                              rsp_channel_index,
   output logic [6:0]                              rsp_frame_index,
   output logic                                    rsp_block_end
);

   pcmdec_pkg::fmt_type    sample_format_ff;
   logic [3:0]             channel_count_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   s1_go;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]     rsp_sample_ff;
   logic [2:0]             rsp_channel_ff;
   logic [6:0]             rsp_frame_ff;
   logic                   rsp_block_end_ff;
   pcmdec_pkg::decode_type dec;
   pcmdec_pkg::tag_type    tag;

   pcmdec_byte_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_go),
      .data_byte     (s1_byte_ff),
      .sample_format (sample_format_ff),
      .decode        (dec)
   );

   pcmdec_sample_tagger #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .MAX_CHANNELS  (MAX_CHANNELS)
   ) u_tagger (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_go && dec.produce),
      .channel_count (channel_count_ff),
      .tag           (tag)
   );

   always_comb begin
      s1_go     = s1_valid_ff && (!dec.produce || !rsp_valid_ff || !rsp_stall);
      req_stall = s1_valid_ff && !s1_go;

      s1_valid_in = s1_valid_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go && dec.produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= pcmdec_pkg::FMT_U8;
         channel_count_ff <= pcmdec_pkg::CHANNEL_COUNT_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == pcmdec_pkg::CSR_SAMPLE_FORMAT) begin
            sample_format_ff <= pcmdec_pkg::fmt_type'(csr_data[2:0]);
         end
         if (csr_write_enable && csr_index == pcmdec_pkg::CSR_CHANNEL_COUNT) begin
            channel_count_ff <= csr_data[3:0];
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_data_byte;
      end
      if (s1_go && dec.produce) begin
         rsp_sample_ff    <= $signed(dec.sample);
         rsp_channel_ff   <= tag.channel_index;
         rsp_frame_ff     <= tag.frame_index;
         rsp_block_end_ff <= tag.block_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_channel_index = rsp_channel_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_block_end     = rsp_block_end_ff;

endmodule

`default_nettype wire

/* hw/rtl/pcmdec_checker.sv */
// Port-level assertions for the PCM sample decoder and the bind that attaches them.
// Depends on pcm_ulaw_sample_decoder_unit.
`default_nettype none

module pcmdec_checker #(
   parameter int BLOCK_SAMPLES = 128
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [6:0]  rsp_frame_index,
   input wire logic        rsp_block_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled result was withdrawn.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("A result is shown right after reset.");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Input stalled while the result register is empty.");

   a_block_end_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_frame_index == 7'(BLOCK_SAMPLES - 1))
      else $error("Block end flagged on a frame that is not the last one.");

endmodule

bind pcm_ulaw_sample_decoder_unit pcmdec_checker #(
   .BLOCK_SAMPLES (BLOCK_SAMPLES)
) u_pcmdec_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_frame_index (rsp_frame_index),
   .rsp_block_end   (rsp_block_end)
);

`default_nettype wire

/* test/pcmdec_sample_checker.sv */
// Checker for the PCM and mu-law sample decoder: watches the byte, result and register
// ports, predicts every decoded sample with its tags and compares each result transfer.
// Depends on pcmdec_pkg for the register indexes, format codes and default sizes.
module pcmdec_sample_checker
   import pcmdec_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic signed [15:0]     rsp_sample,
   input  wire logic [2:0]             rsp_channel_index,
   input  wire logic [6:0]             rsp_frame_index,
   input  wire logic                   rsp_block_end,
   output int                          error_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [2:0]         channel;
      logic [6:0]         frame;
      logic               block_end;
   } sample_entry_type;

   sample_entry_type expected_samples[$];

   logic [2:0] format_reg;
   logic [3:0] channels_reg;
   logic [7:0] held_byte;
   logic       second_byte_due;
   logic [2:0] channel_ctr;
   logic [6:0] frame_ctr;

   function automatic logic [15:0] ulaw_to_linear(input logic [7:0] code);
      logic [7:0] inv;
      int         magnitude;
      inv = ~code;
      magnitude = ((int'(inv[3:0]) * 8 + 132) << inv[6:4]) - 132;
      return inv[7] ? 16'(-magnitude) : 16'(magnitude);
   endfunction

   task automatic decode_byte(input logic [7:0] data);
      logic [15:0]      value;
      int               channels;
      bit               last_channel;
      bit               last_frame;
      sample_entry_type entry;
      channels = (channels_reg == 4'd0) ? 1 : int'(channels_reg);
      if (channels > MAX_CHANNELS_DEFAULT) channels = MAX_CHANNELS_DEFAULT;
      case (format_reg)
         FMT_S8: begin
            second_byte_due = 1'b0;
            value = {data, 8'h00};
         end
         FMT_ULAW: begin
            second_byte_due = 1'b0;
            value = ulaw_to_linear(data);
         end
         FMT_S16LE, FMT_S16BE: begin
            if (!second_byte_due) begin
               held_byte = data;
               second_byte_due = 1'b1;
               return;
            end
            second_byte_due = 1'b0;
            value = (format_reg == FMT_S16LE) ? {data, held_byte} : {held_byte, data};
         end
         default: begin
            second_byte_due = 1'b0;
            value = {~data[7], data[6:0], 8'h00};
         end
      endcase
      last_channel = (int'(channel_ctr) + 1) >= channels;
      last_frame   = (int'(frame_ctr) + 1) >= BLOCK_SAMPLES_DEFAULT;
      entry.sample    = value;
      entry.channel   = channel_ctr;
      entry.frame     = frame_ctr;
      entry.block_end = last_channel && last_frame;
      expected_samples.push_back(entry);
      if (last_channel) begin
         channel_ctr = 3'd0;
         frame_ctr   = last_frame ? 7'd0 : frame_ctr + 7'd1;
      end else begin
         channel_ctr = channel_ctr + 3'd1;
      end
   endtask

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      sample_entry_type want;
      if (reset) begin
         format_reg      = FMT_U8;
         channels_reg    = CHANNEL_COUNT_RESET;
         held_byte       = 8'd0;
         second_byte_due = 1'b0;
         channel_ctr     = 3'd0;
         frame_ctr       = 7'd0;
         error_count     = 0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample transfer: expected none, actual %0d",
                        $time, rsp_sample);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               compare_field("sample", want.sample, rsp_sample);
               compare_field("channel_index", want.channel, rsp_channel_index);
               compare_field("frame_index", want.frame, rsp_frame_index);
               compare_field("block_end", want.block_end, rsp_block_end);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SAMPLE_FORMAT) format_reg = csr_data[2:0];
            else if (csr_index == CSR_CHANNEL_COUNT) channels_reg = csr_data[3:0];
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte);
      end
      pending = expected_samples.size();
   end

endmodule

/* test/tb.sv */
// Top of the decoder testbench: clock, reset, register writes and byte stimulus with
// random idling on both channels. Depends on pcmdec_pkg, pcm_ulaw_sample_decoder_unit
// and pcmdec_sample_checker, which predicts and compares the results.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcmdec_pkg::*;

   localparam int          RANDOM_BYTES  = 1400;
   localparam int          QUIET_BYTES   = 200;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam logic [2:0]  FMT_SPARE_LOW = 3'd5;
   localparam logic [2:0]  FMT_SPARE_TOP = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SAMPLE_FORMAT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [15:0]     rsp_sample;
   logic [2:0]             rsp_channel_index;
   logic [6:0]             rsp_frame_index;
   logic                   rsp_block_end;
   int                     error_count;
   int                     pending;
   int                     cycle_count = 0;
   int                     stall_left = 0;
   int                     bytes_sent = 0;
   bit                     idling = 1'b0;

   pcm_ulaw_sample_decoder_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_channel_index (rsp_channel_index),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_block_end     (rsp_block_end)
   );

   pcmdec_sample_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_channel_index (rsp_channel_index),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_block_end     (rsp_block_end),
      .error_count       (error_count),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] data);
      int gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_config(input logic [2:0] format_code, input logic [3:0] channels);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SAMPLE_FORMAT;
      csr_data         <= {1'($urandom_range(0, 1)), format_code};
      @(negedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_data  <= channels;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          pick;
      int          run_length;
      logic [2:0]  format_code;
      logic [3:0]  channels;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      write_config(FMT_S8, 4'd1);
      send_byte(8'h7F);
      send_byte(8'h80);
      write_config(FMT_ULAW, 4'd1);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
      // The odd byte at the end stays held across the switch to big-endian.
      write_config(FMT_S16LE, 4'd2);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h5A);
      write_config(FMT_S16BE, 4'd2);
      send_byte(8'hA5);
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'h7F);
      write_config(FMT_SPARE_LOW, 4'd0);
      send_byte(8'h33);
      write_config(FMT_S8, 4'd8);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      // Lowering the count below the current channel closes the frame early.
      write_config(FMT_U8, 4'd2);
      send_byte(8'hC0);
      write_config(FMT_SPARE_TOP, 4'd15);
      send_byte(8'h11);
      send_byte(8'h22);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 15);
         format_code = (pick < 14) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
         pick = $urandom_range(0, 15);
         if (pick < 5) channels = 4'd1;
         else if (pick < 13) channels = 4'($urandom_range(2, 8));
         else if (pick == 13) channels = 4'd0;
         else channels = 4'($urandom_range(9, 15));
         write_config(format_code, channels);
         idling = (bytes_sent < RANDOM_BYTES - QUIET_BYTES) && ($urandom_range(0, 9) < 7);
         run_length = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(1, 60);
         if (run_length > RANDOM_BYTES - bytes_sent) run_length = RANDOM_BYTES - bytes_sent;
         repeat (run_length) begin
            if (bytes_sent >= RANDOM_BYTES - QUIET_BYTES) idling = 1'b0;
            send_byte(8'($urandom_range(0, 255)));
         end
      end

      idling = 1'b0;
      wait_idle();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* pcm_ulaw_sample_decoder_unit.f */
hw/rtl/pcmdec_pkg.sv
hw/rtl/pcmdec_byte_decode.sv
hw/rtl/pcmdec_sample_tagger.sv
hw/rtl/pcm_ulaw_sample_decoder_unit.sv
hw/rtl/pcmdec_checker.sv
test/pcmdec_sample_checker.sv
test/tb.sv
